// ===== hw/rtl/fat_entry_locate_decode_macros.svh =====
// assertion helpers used by the checker file
`ifndef FAT_ENTRY_LOCATE_DECODE_MACROS_SVH
`define FAT_ENTRY_LOCATE_DECODE_MACROS_SVH

// same-cycle implication, masked during reset
`define FEL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define FEL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fel_pkg.sv =====
`default_nettype none

package fel_pkg;

    // field widths
    localparam int OP_W        = 1;
    localparam int CLUSTER_W   = 28;
    localparam int RAW_W       = 32;
    localparam int SECTOR_W    = 32;
    localparam int OFFSET_W    = 12;
    localparam int RESV_W      = 16;
    localparam int TYPE_W      = 2;
    localparam int LOG2_W      = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IDX_W       = 30;

    // stream packing
    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 80;

    localparam int M_SECTOR_LSB = 0;
    localparam int M_OFFSET_LSB = M_SECTOR_LSB + SECTOR_W;
    localparam int M_NEXT_LSB   = M_OFFSET_LSB + OFFSET_W;
    localparam int M_EOC_BIT    = M_NEXT_LSB + CLUSTER_W;

    // operations
    localparam logic [OP_W-1:0] OP_LOCATE = 1'b0;
    localparam logic [OP_W-1:0] OP_DECODE = 1'b1;

    // file system variants
    localparam logic [TYPE_W-1:0] FAT_12 = 2'd0;
    localparam logic [TYPE_W-1:0] FAT_16 = 2'd1;
    localparam logic [TYPE_W-1:0] FAT_32 = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FAT_TYPE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESV_SECT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECT_LOG2 = 2'd2;

    // register reset values
    localparam logic [TYPE_W-1:0] FAT_TYPE_RST  = FAT_16;
    localparam logic [RESV_W-1:0] RESV_SECT_RST = 16'd1;
    localparam logic [LOG2_W-1:0] SECT_LOG2_RST = 4'd9;

    // sector size limits
    localparam logic [LOG2_W-1:0] SECT_LOG2_MIN = 4'd9;
    localparam logic [LOG2_W-1:0] SECT_LOG2_MAX = 4'd12;

    // entry decode constants
    localparam logic [CLUSTER_W-1:0] FAT12_EOC  = 28'h0000FF8;
    localparam logic [CLUSTER_W-1:0] FAT16_EOC  = 28'h000FFF8;
    localparam logic [CLUSTER_W-1:0] FAT32_EOC  = 28'hFFFFFF8;
    localparam logic [CLUSTER_W-1:0] FAT32_MASK = 28'hFFFFFFF;
    localparam logic [OFFSET_W-1:0]  FAT12_MASK = 12'hFFF;
    localparam logic [CLUSTER_W-1:0] ODD_BIT    = 28'h0000001;

endpackage

`default_nettype wire

// ===== hw/rtl/fat_entry_locate_decode.sv =====
`default_nettype none
// channel   dir  signals                     contents
// s_        in   s_tvalid/s_tready/s_tdata   cluster, raw_word; s_tuser: operation, read_error
// m_        out  m_tvalid/m_tready/m_tdata   fat_sector, byte_offset, next_cluster, end_of_chain
// cfg_      in   cfg_wr_en/cfg_addr/cfg_wdata fat_type, reserved_sectors, sector_size_log2
//
// one request per cycle unless m_tready stalls it; path: input register, then result register
// two adds (30 and 32 bits) and shift/mask selection form the result between the two registers
// aresetn is synchronous, active low; it clears the valid flags and loads the config defaults
// a stalled result holds in the result register while the input register still takes a request
// s_tready drops only when both registers hold requests and m_tready is low

module fat_entry_locate_decode (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire  [fel_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [fel_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // [27:0] cluster, [59:28] raw_word, [63:60] zero
    input  wire  [fel_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] operation, [1] read_error
    input  wire  [fel_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [31:0] fat_sector, [43:32] byte_offset, [71:44] next_cluster, [72] end_of_chain,
    // [79:73] zero
    output logic [fel_pkg::M_TDATA_W-1:0]       m_tdata
);

    // configuration registers
    logic [fel_pkg::TYPE_W-1:0]     fat_type_reg;
    logic [fel_pkg::RESV_W-1:0]     resv_sect_reg;
    logic [fel_pkg::LOG2_W-1:0]     sect_log2_reg;

    // input stage
    logic                           in_valid_reg;
    logic [fel_pkg::OP_W-1:0]       in_op_reg;
    logic                           in_err_reg;
    logic [fel_pkg::CLUSTER_W-1:0]  in_cluster_reg;
    logic [fel_pkg::RAW_W-1:0]      in_raw_reg;

    // result stage
    logic                           out_valid_reg;
    logic [fel_pkg::M_TDATA_W-1:0]  out_data_reg;
    logic [fel_pkg::M_TDATA_W-1:0]  out_data_next;

    logic                           out_free;
    logic                           s_take;

    // locate path
    logic [fel_pkg::LOG2_W-1:0]     log2_eff;
    logic [fel_pkg::IDX_W-1:0]      entry_idx;
    logic [fel_pkg::IDX_W-10:0]     sect_rel;
    logic [fel_pkg::OFFSET_W-1:0]   entry_off;
    logic [fel_pkg::SECTOR_W-1:0]   fat_sector;

    // decode path
    logic [15:0]                    w16;
    logic [fel_pkg::CLUSTER_W-1:0]  dec_val;
    logic                           dec_eoc;

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign s_take   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_type_reg  <= fel_pkg::FAT_TYPE_RST;
            resv_sect_reg <= fel_pkg::RESV_SECT_RST;
            sect_log2_reg <= fel_pkg::SECT_LOG2_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fel_pkg::CFG_FAT_TYPE:  fat_type_reg  <= cfg_wdata[fel_pkg::TYPE_W-1:0];
                fel_pkg::CFG_RESV_SECT: resv_sect_reg <= cfg_wdata[fel_pkg::RESV_W-1:0];
                fel_pkg::CFG_SECT_LOG2: sect_log2_reg <= cfg_wdata[fel_pkg::LOG2_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_cluster_reg <= s_tdata[fel_pkg::CLUSTER_W-1:0];
            in_raw_reg     <= s_tdata[fel_pkg::CLUSTER_W +: fel_pkg::RAW_W];
            in_op_reg      <= s_tuser[0];
            in_err_reg     <= s_tuser[1];
        end
    end

    // sector size clamp
    always_comb begin
        if (sect_log2_reg < fel_pkg::SECT_LOG2_MIN) begin
            log2_eff = fel_pkg::SECT_LOG2_MIN;
        end else if (sect_log2_reg > fel_pkg::SECT_LOG2_MAX) begin
            log2_eff = fel_pkg::SECT_LOG2_MAX;
        end else begin
            log2_eff = sect_log2_reg;
        end
    end

    // byte index of the entry in the fat
    always_comb begin
        case (fat_type_reg)
            fel_pkg::FAT_32: entry_idx = {in_cluster_reg, 2'b00};
            fel_pkg::FAT_16: entry_idx = {1'b0, in_cluster_reg, 1'b0};
            default:         entry_idx = {2'b00, in_cluster_reg}
                                       + {3'b000, in_cluster_reg[fel_pkg::CLUSTER_W-1:1]};
        endcase
    end

    // split index into sector and offset
    always_comb begin
        case (log2_eff)
            4'd9: begin
                sect_rel  = entry_idx[fel_pkg::IDX_W-1:9];
                entry_off = {3'b000, entry_idx[8:0]};
            end
            4'd10: begin
                sect_rel  = {1'b0, entry_idx[fel_pkg::IDX_W-1:10]};
                entry_off = {2'b00, entry_idx[9:0]};
            end
            4'd11: begin
                sect_rel  = {2'b00, entry_idx[fel_pkg::IDX_W-1:11]};
                entry_off = {1'b0, entry_idx[10:0]};
            end
            default: begin
                sect_rel  = {3'b000, entry_idx[fel_pkg::IDX_W-1:12]};
                entry_off = entry_idx[11:0];
            end
        endcase
    end

    assign fat_sector = {16'h0000, resv_sect_reg}
                      + {{(fel_pkg::SECTOR_W - fel_pkg::IDX_W + 9){1'b0}}, sect_rel};

    // entry word decode
    assign w16 = in_raw_reg[15:0];

    always_comb begin
        dec_val = '0;
        dec_eoc = 1'b0;
        if (!in_err_reg) begin
            case (fat_type_reg)
                fel_pkg::FAT_12: begin
                    if ((in_cluster_reg & fel_pkg::ODD_BIT) != '0) begin
                        dec_val = {16'h0000, w16[15:4]};
                    end else begin
                        dec_val = {16'h0000, w16[11:0] & fel_pkg::FAT12_MASK};
                    end
                    dec_eoc = dec_val >= fel_pkg::FAT12_EOC;
                end
                fel_pkg::FAT_16: begin
                    dec_val = {12'h000, w16};
                    dec_eoc = dec_val >= fel_pkg::FAT16_EOC;
                end
                fel_pkg::FAT_32: begin
                    dec_val = in_raw_reg[fel_pkg::CLUSTER_W-1:0] & fel_pkg::FAT32_MASK;
                    dec_eoc = dec_val >= fel_pkg::FAT32_EOC;
                end
                default: begin
                    dec_val = '0;
                    dec_eoc = 1'b0;
                end
            endcase
        end
    end

    // result word
    always_comb begin
        out_data_next = '0;
        if (in_op_reg == fel_pkg::OP_LOCATE) begin
            out_data_next[fel_pkg::M_SECTOR_LSB +: fel_pkg::SECTOR_W] = fat_sector;
            out_data_next[fel_pkg::M_OFFSET_LSB +: fel_pkg::OFFSET_W] = entry_off;
        end else begin
            out_data_next[fel_pkg::M_NEXT_LSB +: fel_pkg::CLUSTER_W] = dec_val;
            out_data_next[fel_pkg::M_EOC_BIT]                        = dec_eoc;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fel_checker.sv =====
`default_nettype none
`include "fat_entry_locate_decode_macros.svh"

module fel_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [fel_pkg::M_TDATA_W-1:0]     m_tdata
);

    // result fields as seen on the port
    logic [fel_pkg::SECTOR_W-1:0]   chk_sector;
    logic [fel_pkg::OFFSET_W-1:0]   chk_offset;
    logic [fel_pkg::CLUSTER_W-1:0]  chk_next;
    logic                           chk_eoc;

    // derived conditions
    logic                           stalled;
    logic                           loc_zero;
    logic                           dec_zero;
    logic                           eoc_seen;
    logic                           low_next;

    assign chk_sector = m_tdata[fel_pkg::M_SECTOR_LSB +: fel_pkg::SECTOR_W];
    assign chk_offset = m_tdata[fel_pkg::M_OFFSET_LSB +: fel_pkg::OFFSET_W];
    assign chk_next   = m_tdata[fel_pkg::M_NEXT_LSB +: fel_pkg::CLUSTER_W];
    assign chk_eoc    = m_tdata[fel_pkg::M_EOC_BIT];

    assign stalled  = m_tvalid && !m_tready;
    assign loc_zero = (chk_sector == '0) && (chk_offset == '0);
    assign dec_zero = (chk_next == '0) && !chk_eoc;
    assign eoc_seen = m_tvalid && chk_eoc;
    assign low_next = chk_next < fel_pkg::FAT12_EOC;

    // a stalled result stays offered
    `FEL_ASSERT_NXT(a_hold_valid, aclk, aresetn, stalled, m_tvalid, "result dropped while stalled")

    // a stalled result keeps its data
    `FEL_ASSERT_NXT(a_hold_data, aclk, aresetn, stalled, $stable(m_tdata), "stalled data changed")

    // a result carries either locate fields or decode fields, never both
    `FEL_ASSERT_IMP(a_one_kind, aclk, aresetn, m_tvalid, loc_zero || dec_zero, "mixed fields")

    // end of chain only for values at or above the smallest threshold
    `FEL_ASSERT_IMP(a_eoc_range, aclk, aresetn, eoc_seen, !low_next, "low value marked end")

endmodule

bind fat_entry_locate_decode fel_checker u_fel_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;

    // one request as the block sees it
    typedef struct packed {
        logic [fel_pkg::OP_W-1:0]      op;
        logic [fel_pkg::CLUSTER_W-1:0] cluster;
        logic [fel_pkg::RAW_W-1:0]     raw_word;
        logic                          read_error;
    } fat_request_t;

    // one result, fields as unpacked from m_tdata
    typedef struct packed {
        logic [fel_pkg::SECTOR_W-1:0]  fat_sector;
        logic [fel_pkg::OFFSET_W-1:0]  byte_offset;
        logic [fel_pkg::CLUSTER_W-1:0] next_cluster;
        logic                          end_of_chain;
    } fat_result_t;

    // variant code with no file system behind it
    localparam logic [fel_pkg::TYPE_W-1:0] FAT_NONE = 2'd3;

    // entry lookup predictor with its own register copy and queue of pending results
    class fat_entry_board;
        logic [fel_pkg::TYPE_W-1:0] fat_type;
        logic [fel_pkg::RESV_W-1:0] resv_sectors;
        logic [fel_pkg::LOG2_W-1:0] sect_log2;
        fat_result_t                pending_results[$];
        int                         errors;

        function new();
            fat_type     = fel_pkg::FAT_TYPE_RST;
            resv_sectors = fel_pkg::RESV_SECT_RST;
            sect_log2    = fel_pkg::SECT_LOG2_RST;
            errors       = 0;
        endfunction

        function void set_register(logic [fel_pkg::CFG_ADDR_W-1:0] addr,
                                   logic [fel_pkg::CFG_DATA_W-1:0] value);
            case (addr)
                fel_pkg::CFG_FAT_TYPE:  fat_type     = value[fel_pkg::TYPE_W-1:0];
                fel_pkg::CFG_RESV_SECT: resv_sectors = value[fel_pkg::RESV_W-1:0];
                fel_pkg::CFG_SECT_LOG2: sect_log2    = value[fel_pkg::LOG2_W-1:0];
                default: ;
            endcase
        endfunction

        function fat_result_t lookup_entry(fat_request_t req);
            fat_result_t                res;
            logic [31:0]                n32;
            logic [31:0]                idx;
            logic [31:0]                off32;
            logic [fel_pkg::LOG2_W-1:0] shift;
            logic [15:0]                w16;
            res = '0;
            n32 = {4'b0, req.cluster};
            if (req.op == fel_pkg::OP_LOCATE) begin
                // sector size saturates to the supported range
                if (sect_log2 < fel_pkg::SECT_LOG2_MIN) shift = fel_pkg::SECT_LOG2_MIN;
                else if (sect_log2 > fel_pkg::SECT_LOG2_MAX) shift = fel_pkg::SECT_LOG2_MAX;
                else shift = sect_log2;
                // byte index of the entry; unknown variant falls back to the 12-bit form
                case (fat_type)
                    fel_pkg::FAT_32: idx = n32 << 2;
                    fel_pkg::FAT_16: idx = n32 << 1;
                    default:         idx = n32 + (n32 >> 1);
                endcase
                off32 = idx & ((32'd1 << shift) - 32'd1);
                res.fat_sector  = {16'b0, resv_sectors} + (idx >> shift);
                res.byte_offset = off32[fel_pkg::OFFSET_W-1:0];
            end else if (!req.read_error) begin
                w16 = req.raw_word[15:0];
                case (fat_type)
                    fel_pkg::FAT_12: begin
                        // odd clusters sit in the upper 12 bits of the pair
                        if ((req.cluster & fel_pkg::ODD_BIT) != '0)
                            res.next_cluster = {16'b0, w16[15:4]};
                        else
                            res.next_cluster = {16'b0, w16[11:0] & fel_pkg::FAT12_MASK};
                        res.end_of_chain = (res.next_cluster >= fel_pkg::FAT12_EOC);
                    end
                    fel_pkg::FAT_16: begin
                        res.next_cluster = {12'b0, w16};
                        res.end_of_chain = (res.next_cluster >= fel_pkg::FAT16_EOC);
                    end
                    fel_pkg::FAT_32: begin
                        res.next_cluster = req.raw_word[fel_pkg::CLUSTER_W-1:0]
                                         & fel_pkg::FAT32_MASK;
                        res.end_of_chain = (res.next_cluster >= fel_pkg::FAT32_EOC);
                    end
                    default: ;
                endcase
            end
            return res;
        endfunction

        function void note_request(fat_request_t req);
            pending_results.push_back(lookup_entry(req));
        endfunction

        function void check_result(fat_result_t got);
            fat_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: sector %h offset %h next %h eoc %b",
                             got.fat_sector, got.byte_offset, got.next_cluster,
                             got.end_of_chain);
                return;
            end
            want = pending_results.pop_front();
            if (got.fat_sector !== want.fat_sector || got.byte_offset !== want.byte_offset ||
                got.next_cluster !== want.next_cluster ||
                got.end_of_chain !== want.end_of_chain) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: sector %h/%h offset %h/%h next %h/%h eoc %b/%b (exp/got)",
                             want.fat_sector, got.fat_sector, want.byte_offset,
                             got.byte_offset, want.next_cluster, got.next_cluster,
                             want.end_of_chain, got.end_of_chain);
            end
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [fel_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [fel_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [fel_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [fel_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [fel_pkg::M_TDATA_W-1:0]  m_tdata;

    fat_entry_board board;
    int send_idle_pct = 9;
    int recv_idle_pct = 83;

    fat_entry_locate_decode dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // note accepted requests
    always @(posedge aclk) begin
        fat_request_t req;
        if (aresetn && s_tvalid && s_tready) begin
            req.op         = s_tuser[0];
            req.read_error = s_tuser[1];
            req.cluster    = s_tdata[fel_pkg::CLUSTER_W-1:0];
            req.raw_word   = s_tdata[fel_pkg::CLUSTER_W +: fel_pkg::RAW_W];
            board.note_request(req);
        end
    end

    // check accepted results
    always @(posedge aclk) begin
        fat_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.fat_sector   = m_tdata[fel_pkg::M_SECTOR_LSB +: fel_pkg::SECTOR_W];
            got.byte_offset  = m_tdata[fel_pkg::M_OFFSET_LSB +: fel_pkg::OFFSET_W];
            got.next_cluster = m_tdata[fel_pkg::M_NEXT_LSB +: fel_pkg::CLUSTER_W];
            got.end_of_chain = m_tdata[fel_pkg::M_EOC_BIT];
            board.check_result(got);
        end
    end

    task automatic send_request(input fat_request_t req);
        // random gap before the request
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, req.raw_word, req.cluster};
        s_tuser  <= {req.read_error, req.op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [fel_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [fel_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_register(addr, value);
    endtask

    // drain, then load all three registers
    task automatic apply_settings(input logic [fel_pkg::TYPE_W-1:0] ftype,
                                  input logic [fel_pkg::RESV_W-1:0] resv,
                                  input logic [fel_pkg::LOG2_W-1:0] log2);
        s_tvalid <= 1'b0;
        wait_idle();
        write_register(fel_pkg::CFG_FAT_TYPE,
                       {{(fel_pkg::CFG_DATA_W-fel_pkg::TYPE_W){1'b0}}, ftype});
        write_register(fel_pkg::CFG_RESV_SECT, resv);
        write_register(fel_pkg::CFG_SECT_LOG2,
                       {{(fel_pkg::CFG_DATA_W-fel_pkg::LOG2_W){1'b0}}, log2});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic fat_request_t make_request(logic [fel_pkg::OP_W-1:0] op,
                                                  logic [fel_pkg::CLUSTER_W-1:0] cluster,
                                                  logic [fel_pkg::RAW_W-1:0] raw, logic rerr);
        fat_request_t req;
        req.op         = op;
        req.cluster    = cluster;
        req.raw_word   = raw;
        req.read_error = rerr;
        return req;
    endfunction

    // random request, biased towards chain ends and extreme clusters
    function automatic fat_request_t random_request();
        fat_request_t req;
        req.op = $urandom_range(0, 1) ? fel_pkg::OP_DECODE : fel_pkg::OP_LOCATE;
        case ($urandom_range(0, 7))
            0:       req.cluster = '0;
            1:       req.cluster = '1;
            2:       req.cluster = fel_pkg::CLUSTER_W'($urandom_range(0, 4095));
            default: req.cluster = fel_pkg::CLUSTER_W'($urandom);
        endcase
        req.raw_word = $urandom;
        case ($urandom_range(0, 3))
            0:       req.raw_word = req.raw_word | 32'h0FFF_FFF0;
            1:       req.raw_word = req.raw_word & 32'hF000_F00F;
            default: ;
        endcase
        req.read_error = ($urandom_range(0, 7) == 0);
        return req;
    endfunction

    // short directed set under the current settings
    task automatic send_directed();
        send_request(make_request(fel_pkg::OP_LOCATE, '0, 32'h0, 1'b0));
        send_request(make_request(fel_pkg::OP_LOCATE, '1, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(fel_pkg::OP_DECODE, 28'd1, 32'hFFFF_FFFF, 1'b0));
        send_request(make_request(fel_pkg::OP_DECODE, 28'd2, 32'h0FFF_FFF7, 1'b0));
        send_request(make_request(fel_pkg::OP_DECODE, 28'd3, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(fel_pkg::OP_DECODE, '0, 32'h0, 1'b0));
    endtask

    initial begin
        logic [fel_pkg::LOG2_W-1:0] log2_choice [12];
        logic [fel_pkg::RESV_W-1:0] resv;
        board = new();
        log2_choice = '{4'd9, 4'd12, 4'd10, 4'd0, 4'd15, 4'd11,
                        4'd9, 4'd12, 4'd8, 4'd13, 4'd10, 4'd11};

        // synchronous reset held at start, then released
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings first, then each variant and sector size extremes
        send_directed();
        apply_settings(fel_pkg::FAT_12, 16'h0000, 4'd9);
        send_directed();
        apply_settings(fel_pkg::FAT_32, 16'hFFFF, 4'd12);
        send_directed();
        apply_settings(FAT_NONE, 16'd1, 4'd15);
        send_directed();

        // random segments: every variant under each idling pattern
        for (int seg = 0; seg < 12; seg++) begin
            if (seg == 1) resv = 16'hFFFF;
            else if (seg == 2) resv = 16'h0000;
            else resv = fel_pkg::RESV_W'($urandom);
            apply_settings(fel_pkg::TYPE_W'(seg % 4), resv, log2_choice[seg]);
            case (seg / 4)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < 70; i++)
                send_request(random_request());
        end

        // drain and report
        s_tvalid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge aclk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
